// ===== hdl/bplfm_pkg.sv =====
// bplfm_pkg: shared types and constants of the buffer pool frame manager
// no dependencies
`default_nettype none
package bplfm_pkg;
   localparam int NumFramesDefault = 16;
   localparam int PageIdBitsDefault = 16;
   localparam int StampBits = 32;
   localparam int CountBits = 32;
   localparam int PortIdBits = 16;

   localparam logic [2:0] OP_READ   = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_DIRTY  = 3'd2;
   localparam logic [2:0] OP_UNPIN  = 3'd3;
   localparam logic [2:0] OP_FLUSH  = 3'd4;
   localparam logic [2:0] OP_EVICT  = 3'd5;

   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_LOADED   = 3'd1;
   localparam logic [2:0] ST_NOFRAME  = 3'd2;
   localparam logic [2:0] ST_INVALID  = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_DONE     = 3'd5;

   // request item fields from the lowest bit: operation, page_id, page_valid
   typedef struct packed {
      logic        page_valid;
      logic [15:0] page_id;
      logic [2:0]  operation;
   } req_type;

   // result item fields from the lowest bit
   typedef struct packed {
      logic [31:0] miss_count;
      logic [31:0] hit_count;
      logic [15:0] writeback_page;
      logic        writeback_valid;
      logic [3:0]  frame_index;
      logic [2:0]  status;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hdl/bplfm_frame_ram.sv =====
// bplfm_frame_ram: frame table memory, one write and one registered read port
// no dependencies
`default_nettype none
module bplfm_frame_ram #(
   parameter int Depth = 16,
   parameter int Width = 48,
   parameter int AddrBits = 4
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AddrBits-1:0] wr_addr,
   input  wire logic [Width-1:0]    wr_data,
   input  wire logic [AddrBits-1:0] rd_addr,
   output logic      [Width-1:0]    rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hdl/buffer_pool_lru_frame_manager.sv =====
// buffer_pool_lru_frame_manager: top level, scan sequencer over the frame memory
// depends on bplfm_pkg and bplfm_frame_ram
//
//  channel | ports        | content
//  request | req_t*       | operation, page_id, page_valid
//  result  | rsp_t*       | status, frame_index, writeback, hit and miss counts
//
// an item passes from acceptance through the scan state, with one frame memory read per
// scan cycle, the decide state, which writes the frame memory for a read or insert that hits
// or loads, the wait state and the idle state before the next acceptance; the result is
// registered in the decide state and ready is low while an item is in work
// reset clears per-frame used, dirty and pinned bits; stamps of empty frames read as zero
// a result waiting in the output register does not stop the next item's scan, it holds
// the decide cycle until it is taken
`default_nettype none
module buffer_pool_lru_frame_manager
   import bplfm_pkg::*;
#(
   parameter int FRAME_COUNT = NumFramesDefault,
   parameter int PAGE_ID_BITS = PageIdBitsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [23:0]  req_tdata,  // operation, page_id, page_valid, upper bits ignored
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [87:0]       rsp_tdata   // status, frame_index, writeback_valid,
                                         // writeback_page, hit_count, miss_count
);
   localparam int AddrBits = $clog2(FRAME_COUNT+1);
   localparam int IdxBits = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int RamWidth = PAGE_ID_BITS + StampBits;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_WAIT} state_type;

   state_type state_ff;
   req_type req_ff;
   logic [AddrBits-1:0] cnt_ff;
   logic [AddrBits-1:0] rd_cnt_ff;
   logic rd_act_ff;
   logic [FRAME_COUNT-1:0] used_ff, dirty_ff, pinned_ff;
   logic [StampBits-1:0] time_ff, hits_ff, misses_ff;
   logic hit_fnd_ff, emp_fnd_ff, vic_fnd_ff;
   logic [IdxBits-1:0] hit_idx_ff, emp_idx_ff, vic_idx_ff;
   logic [StampBits-1:0] vic_stamp_ff;
   logic [PAGE_ID_BITS-1:0] vic_page_ff, hit_page_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic wr_en;
   logic [IdxBits-1:0] wr_addr, rd_addr;
   logic [RamWidth-1:0] wr_data, rd_data;
   logic [PAGE_ID_BITS-1:0] rd_page, req_id;
   logic [StampBits-1:0] rd_stamp, nxt_time;
   logic [IdxBits-1:0] ri;
   logic out_free;

   bplfm_frame_ram #(.Depth(FRAME_COUNT), .Width(RamWidth), .AddrBits(IdxBits)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign rd_addr = (cnt_ff < AddrBits'(FRAME_COUNT)) ? cnt_ff[IdxBits-1:0] : '0;
   assign rd_page = rd_data[RamWidth-1:StampBits];
   assign ri = rd_cnt_ff[IdxBits-1:0];
   assign rd_stamp = used_ff[ri] ? rd_data[StampBits-1:0] : '0;
   assign req_id = PAGE_ID_BITS'(req_ff.page_id);
   assign nxt_time = (&time_ff) ? time_ff : time_ff + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_ff;

   // decide-cycle result and write to the frame memory
   logic have_frame, load_ok, decide_go;
   logic [IdxBits-1:0] tgt;
   logic [CountBits-1:0] hits_inc, misses_inc;
   rsp_type rsp_in;
   always_comb begin
      have_frame = emp_fnd_ff || vic_fnd_ff;
      tgt = emp_fnd_ff ? emp_idx_ff : vic_idx_ff;
      load_ok = have_frame && req_ff.page_valid;
      decide_go = (state_ff == S_DECIDE) && out_free;
      hits_inc = (&hits_ff) ? hits_ff : hits_ff + 1'b1;
      misses_inc = (&misses_ff) ? misses_ff : misses_ff + 1'b1;
      rsp_in.status = ST_NOTFOUND;
      rsp_in.frame_index = '0;
      rsp_in.writeback_valid = 1'b0;
      rsp_in.writeback_page = '0;
      rsp_in.hit_count = hits_ff;
      rsp_in.miss_count = misses_ff;
      wr_en = 1'b0;
      wr_addr = tgt;
      wr_data = {req_id, nxt_time};
      if (req_ff.operation <= OP_INSERT) begin
         if (hit_fnd_ff) begin
            rsp_in.status = ST_HIT;
            rsp_in.frame_index = 4'(hit_idx_ff);
            rsp_in.hit_count = hits_inc;
            wr_en = decide_go;
            wr_addr = hit_idx_ff;
            wr_data = {hit_page_ff, nxt_time};
         end else if (!have_frame) begin
            rsp_in.status = ST_NOFRAME;
         end else begin
            rsp_in.frame_index = 4'(tgt);
            if (!emp_fnd_ff && dirty_ff[tgt]) begin
               rsp_in.writeback_valid = 1'b1;
               rsp_in.writeback_page = 16'(vic_page_ff);
            end
            if (load_ok) begin
               rsp_in.status = ST_LOADED;
               rsp_in.miss_count = misses_inc;
               wr_en = decide_go;
            end else begin
               rsp_in.status = ST_INVALID;
            end
         end
      end else if (req_ff.operation <= OP_EVICT && hit_fnd_ff) begin
         rsp_in.status = ST_DONE;
         rsp_in.frame_index = 4'(hit_idx_ff);
         if ((req_ff.operation == OP_FLUSH || req_ff.operation == OP_EVICT) &&
             dirty_ff[hit_idx_ff]) begin
            rsp_in.writeback_valid = 1'b1;
            rsp_in.writeback_page = 16'(hit_page_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         dirty_ff <= '0;
         pinned_ff <= '0;
         time_ff <= '0;
         hits_ff <= '0;
         misses_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_act_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (decide_go) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  req_ff <= req_type'(req_tdata[19:0]);
                  cnt_ff <= '0;
                  rd_act_ff <= 1'b0;
                  hit_fnd_ff <= 1'b0;
                  emp_fnd_ff <= 1'b0;
                  vic_fnd_ff <= 1'b0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // issue read of cnt, examine previous read
               rd_cnt_ff <= cnt_ff;
               rd_act_ff <= (cnt_ff < AddrBits'(FRAME_COUNT));
               if (cnt_ff < AddrBits'(FRAME_COUNT)) cnt_ff <= cnt_ff + 1'b1;
               if (rd_act_ff) begin
                  if (!hit_fnd_ff && used_ff[ri] && rd_page == req_id) begin
                     hit_fnd_ff <= 1'b1;
                     hit_idx_ff <= ri;
                     hit_page_ff <= rd_page;
                  end
                  if (!emp_fnd_ff && !used_ff[ri]) begin
                     emp_fnd_ff <= 1'b1;
                     emp_idx_ff <= ri;
                  end
                  if (!pinned_ff[ri] && (!vic_fnd_ff || rd_stamp < vic_stamp_ff)) begin
                     vic_fnd_ff <= 1'b1;
                     vic_idx_ff <= ri;
                     vic_stamp_ff <= rd_stamp;
                     vic_page_ff <= rd_page;
                  end
               end else if (cnt_ff == AddrBits'(FRAME_COUNT)) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (out_free) begin
                  rsp_ff <= rsp_in;
                  state_ff <= S_WAIT;
                  if (req_ff.operation <= OP_INSERT) begin
                     if (hit_fnd_ff) begin
                        time_ff <= nxt_time;
                        pinned_ff[hit_idx_ff] <= 1'b1;
                        hits_ff <= hits_inc;
                     end else if (have_frame) begin
                        if (req_ff.page_valid) begin
                           used_ff[tgt] <= 1'b1;
                           dirty_ff[tgt] <= (req_ff.operation == OP_INSERT);
                           pinned_ff[tgt] <= 1'b1;
                           time_ff <= nxt_time;
                           misses_ff <= misses_inc;
                        end else begin
                           used_ff[tgt] <= 1'b0;
                           dirty_ff[tgt] <= 1'b0;
                           pinned_ff[tgt] <= 1'b0;
                        end
                     end
                  end else if (req_ff.operation <= OP_EVICT && hit_fnd_ff) begin
                     case (req_ff.operation)
                        OP_DIRTY: dirty_ff[hit_idx_ff] <= 1'b1;
                        OP_UNPIN: pinned_ff[hit_idx_ff] <= 1'b0;
                        OP_FLUSH, OP_EVICT: begin
                           dirty_ff[hit_idx_ff] <= 1'b0;
                           if (req_ff.operation == OP_EVICT) begin
                              used_ff[hit_idx_ff] <= 1'b0;
                              pinned_ff[hit_idx_ff] <= 1'b0;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
            S_WAIT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("accepted while busy");
   a_rsp_after_decide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> rsp_valid_ff || $past(rsp_tready))
      else $error("result lost");
   a_hits_mono: assert property (@(posedge clock) disable iff (reset)
      hits_ff >= $past(hits_ff) || $past(reset)) else $error("hit count fell");
endmodule
`default_nettype wire
